### hw/rtl/ata_pkg.sv
`timescale 1ns / 1ps
package ata_pkg;

   localparam int MediaSectors   = 64;
   localparam int WordsPerSector = 256;
   localparam int Drives         = 2;
   localparam int MediaWords     = Drives * MediaSectors * WordsPerSector;
   localparam int MediaAw        = $clog2(MediaWords);
   localparam int SecAw          = $clog2(MediaSectors);
   localparam int DrvAw          = (Drives > 1) ? $clog2(Drives) : 1;

   // register offsets
   localparam logic [3:0] OFF_DATA    = 4'd0;
   localparam logic [3:0] OFF_ERROR   = 4'd1;
   localparam logic [3:0] OFF_COUNT   = 4'd2;
   localparam logic [3:0] OFF_LBA0    = 4'd3;
   localparam logic [3:0] OFF_LBA1    = 4'd4;
   localparam logic [3:0] OFF_LBA2    = 4'd5;
   localparam logic [3:0] OFF_DEVSEL  = 4'd6;
   localparam logic [3:0] OFF_STATUS  = 4'd7;
   localparam logic [3:0] OFF_CONTROL = 4'd8;

   // configuration indexes
   localparam logic [2:0] CSR_PRESENT = 3'd0;
   localparam logic [2:0] CSR_TOTAL   = 3'd1;
   localparam logic [2:0] CSR_CYL     = 3'd2;
   localparam logic [2:0] CSR_HEADS   = 3'd3;
   localparam logic [2:0] CSR_SPT     = 3'd4;

   // commands
   localparam logic [7:0] CMD_READ  = 8'h20;
   localparam logic [7:0] CMD_WRITE = 8'h30;
   localparam logic [7:0] CMD_IDENT = 8'hEC;
   localparam logic [7:0] CMD_DIAG  = 8'h90;

   localparam logic [7:0] ST_READY = 8'h40;
   localparam logic [7:0] ST_DRQ   = 8'h48;
   localparam logic [7:0] ST_FAIL  = 8'h41;
   localparam logic [7:0] ERR_IDNF = 8'h10;
   localparam logic [7:0] ERR_ABRT = 8'h04;
   localparam logic [7:0] ERR_DIAG = 8'h01;

   typedef enum logic [1:0] {
      XFER_IDLE  = 2'd0,
      XFER_READ  = 2'd1,
      XFER_WRITE = 2'd2,
      XFER_IDENT = 2'd3
   } xfer_type;

   // classified access handed from front to back
   typedef struct packed {
      logic        wr;
      logic [3:0]  off;
      logic [15:0] wdata;
   } acc_type;

endpackage

### hw/rtl/ata_front.sv
`timescale 1ns / 1ps
// Input side: takes items into a two-entry queue.
module ata_front import ata_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [3:0]  req_reg_offset,
   input  logic [15:0] req_write_data,
   output logic        q_valid,
   output acc_type     q_data,
   input  logic        q_pop
);
   acc_type    mem_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wp_ff, wp_in;
   logic       push;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = mem_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
      wp_in  = wp_ff ^ push;
      rd_in  = rd_ff ^ q_pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wp_ff  <= wp_in;
      end
      if (push) mem_ff[wp_ff] <= '{wr: req_cmd, off: req_reg_offset, wdata: req_write_data};
   end
endmodule

### hw/rtl/ata_back.sv
`timescale 1ns / 1ps
// Executes one register access per item; media data reads wait for the
// registered read of the media RAM.
module ata_back import ata_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [27:0] csr_data,
   input  logic        q_valid,
   input  acc_type     q_data,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_read_data,
   output logic        rsp_irq
);
   logic [1:0]  present_ff;
   logic [27:0] total_ff;
   logic [15:0] cyl_ff;
   logic [7:0]  heads_ff, spt_ff;

   logic [7:0]  feature_ff, feature_in, count_ff, count_in, devsel_ff, devsel_in;
   logic [7:0]  status_ff, status_in, error_ff, error_in, control_ff, control_in;
   logic [27:0] lba_ff, lba_in;
   logic        irq_ff, irq_in;
   xfer_type    kind_ff, kind_in;
   logic [7:0]  widx_ff, widx_in;
   logic [8:0]  left_ff, left_in;

   logic [15:0] media [MediaWords];
   logic [15:0] mrd_ff;
   logic        mwait_ff;

   // output register
   logic        ov_ff;
   logic [15:0] od_ff, od_in;
   logic        oi_ff;
   logic        od_media;

   logic        here, do_exec, mwe;
   logic [MediaAw-1:0] maddr;
   logic [16:0] msec;
   logic [7:0]  b;
   logic [DrvAw-1:0] drv;

   assign b   = q_data.wdata[7:0];
   assign drv = DrvAw'(devsel_ff[4]);
   assign here = (32'(devsel_ff[4]) < Drives) && present_ff[devsel_ff[4]];
   // sector slot over both drives; anything past the store lands on word 0
   assign msec  = (17'(drv) << SecAw) + 17'(lba_ff[15:0]);
   assign maddr = (msec < 17'(Drives * MediaSectors)) ?
                  MediaAw'({msec[SecAw+DrvAw-1:0], widx_ff}) : '0;

   // a data read from media waits for the registered RAM read
   logic is_mread;
   assign is_mread = !q_data.wr && q_data.off == OFF_DATA && here && kind_ff == XFER_READ;
   assign do_exec  = q_valid && (!ov_ff || !rsp_stall) && (!is_mread || mwait_ff);
   assign q_pop    = do_exec;
   assign rsp_valid = ov_ff;
   assign rsp_read_data = od_ff;
   assign rsp_irq = oi_ff;

   function automatic logic sec_ok(input logic [27:0] l, input logic [27:0] t);
      return (l < t) && (l < 28'(MediaSectors));
   endfunction

   function automatic logic [15:0] ident(input logic [7:0] i, input logic [15:0] c,
         input logic [7:0] h, input logic [7:0] s, input logic [27:0] t);
      case (i)
         8'd0:  return 16'h0040;
         8'd1:  return c;
         8'd3:  return {8'h00, h};
         8'd6:  return {8'h00, s};
         8'd49: return 16'h0200;
         8'd60: return t[15:0];
         8'd61: return {4'h0, t[27:16]};
         default: return 16'h0000;
      endcase
   endfunction

   always_comb begin
      logic [27:0] nl;
      feature_in = feature_ff; count_in = count_ff; devsel_in = devsel_ff;
      status_in = status_ff; error_in = error_ff; control_in = control_ff;
      lba_in = lba_ff; irq_in = irq_ff; kind_in = kind_ff;
      widx_in = widx_ff; left_in = left_ff;
      od_in = 16'h0000; od_media = 1'b0; mwe = 1'b0;
      nl = lba_ff + 28'd1;
      if (!q_data.wr) begin
         if (here) begin
            case (q_data.off)
               OFF_DATA: begin
                  if (kind_ff == XFER_READ || kind_ff == XFER_IDENT) begin
                     od_media = (kind_ff == XFER_READ);
                     if (kind_ff == XFER_IDENT)
                        od_in = ident(widx_ff, cyl_ff, heads_ff, spt_ff, total_ff);
                     widx_in = widx_ff + 8'd1;
                     if (widx_ff == 8'hFF) begin
                        if (kind_ff == XFER_IDENT) begin
                           kind_in = XFER_IDLE; status_in = ST_READY; left_in = '0;
                        end else begin
                           lba_in = nl;
                           devsel_in = {devsel_ff[7:4], nl[27:24]};
                           left_in = left_ff - 9'd1;
                           if (left_ff == 9'd1) begin
                              kind_in = XFER_IDLE; status_in = ST_READY;
                           end else if (sec_ok(nl, total_ff)) begin
                              status_in = ST_DRQ; irq_in = 1'b1;
                           end else begin
                              error_in = ERR_IDNF; status_in = ST_FAIL;
                              irq_in = 1'b1; kind_in = XFER_IDLE;
                           end
                        end
                     end
                  end
               end
               OFF_ERROR:   od_in = {8'h00, error_ff};
               OFF_COUNT:   od_in = {8'h00, count_ff};
               OFF_LBA0:    od_in = {8'h00, lba_ff[7:0]};
               OFF_LBA1:    od_in = {8'h00, lba_ff[15:8]};
               OFF_LBA2:    od_in = {8'h00, lba_ff[23:16]};
               OFF_DEVSEL:  od_in = {8'h00, devsel_ff};
               OFF_STATUS:  begin od_in = {8'h00, status_ff}; irq_in = 1'b0; end
               OFF_CONTROL: od_in = {8'h00, status_ff};
               default: ;
            endcase
         end
      end else if (q_data.off == OFF_DEVSEL) begin
         devsel_in = b;
         lba_in = {b[3:0], lba_ff[23:0]};
      end else if (q_data.off == OFF_CONTROL) begin
         control_in = b;
         if (b[2]) begin
            count_in = 8'd1; lba_in = 28'd1; devsel_in = {devsel_ff[7:4], 4'h0};
            error_in = ERR_DIAG; status_in = ST_READY; kind_in = XFER_IDLE;
            irq_in = 1'b0; widx_in = '0; left_in = '0;
         end
      end else if (here) begin
         case (q_data.off)
            OFF_DATA: begin
               if (kind_ff == XFER_WRITE) begin
                  mwe = 1'b1;
                  widx_in = widx_ff + 8'd1;
                  if (widx_ff == 8'hFF) begin
                     lba_in = nl;
                     devsel_in = {devsel_ff[7:4], nl[27:24]};
                     left_in = left_ff - 9'd1;
                     irq_in = 1'b1;
                     if (left_ff == 9'd1) begin
                        kind_in = XFER_IDLE; status_in = ST_READY;
                     end else if (sec_ok(nl, total_ff)) begin
                        status_in = ST_DRQ;
                     end else begin
                        error_in = ERR_IDNF; status_in = ST_FAIL; kind_in = XFER_IDLE;
                     end
                  end
               end
            end
            OFF_ERROR: feature_in = b;
            OFF_COUNT: count_in = b;
            OFF_LBA0:  lba_in = {lba_ff[27:8], b};
            OFF_LBA1:  lba_in = {lba_ff[27:16], b, lba_ff[7:0]};
            OFF_LBA2:  lba_in = {lba_ff[27:24], b, lba_ff[15:0]};
            OFF_STATUS: begin
               kind_in = XFER_IDLE; widx_in = '0; left_in = '0;
               if (b == CMD_READ || b == CMD_WRITE) begin
                  error_in = 8'h00;
                  if (!sec_ok(lba_ff, total_ff)) begin
                     error_in = ERR_IDNF; status_in = ST_FAIL; irq_in = 1'b1;
                  end else begin
                     left_in = (count_ff == 8'd0) ? 9'd256 : {1'b0, count_ff};
                     kind_in = (b == CMD_READ) ? XFER_READ : XFER_WRITE;
                     status_in = ST_DRQ;
                     if (b == CMD_READ) irq_in = 1'b1;
                  end
               end else if (b == CMD_IDENT) begin
                  error_in = 8'h00; left_in = 9'd1; kind_in = XFER_IDENT;
                  status_in = ST_DRQ; irq_in = 1'b1;
               end else if (b == CMD_DIAG) begin
                  count_in = 8'd1; lba_in = 28'd1; devsel_in = {devsel_ff[7:4], 4'h0};
                  error_in = ERR_DIAG; status_in = ST_READY; kind_in = XFER_IDLE;
                  irq_in = 1'b1;
               end else begin
                  error_in = ERR_ABRT; status_in = ST_FAIL; irq_in = 1'b1;
                  kind_in = XFER_IDLE;
               end
            end
            default: ;
         endcase
      end
   end

   // media RAM, registered read
   always_ff @(posedge clock) begin
      if (mwe && do_exec) media[maddr] <= q_data.wdata;
      mrd_ff <= media[maddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 2'd1; total_ff <= 28'd64; cyl_ff <= 16'd1;
         heads_ff <= 8'd2; spt_ff <= 8'd32;
         feature_ff <= '0; count_ff <= 8'd1; lba_ff <= 28'd1; devsel_ff <= '0;
         status_ff <= ST_READY; error_ff <= ERR_DIAG; control_ff <= '0;
         irq_ff <= 1'b0; kind_ff <= XFER_IDLE; widx_ff <= '0; left_ff <= '0;
         ov_ff <= 1'b0; mwait_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_PRESENT: present_ff <= csr_data[1:0];
               CSR_TOTAL:   total_ff   <= csr_data;
               CSR_CYL:     cyl_ff     <= csr_data[15:0];
               CSR_HEADS:   heads_ff   <= csr_data[7:0];
               CSR_SPT:     spt_ff     <= csr_data[7:0];
               default: ;
            endcase
         end
         // stays set while the read waits on a stalled output
         mwait_ff <= q_valid && is_mread;
         if (do_exec) begin
            feature_ff <= feature_in; count_ff <= count_in; devsel_ff <= devsel_in;
            status_ff <= status_in; error_ff <= error_in; control_ff <= control_in;
            lba_ff <= lba_in; irq_ff <= irq_in; kind_ff <= kind_in;
            widx_ff <= widx_in; left_ff <= left_in;
            ov_ff <= 1'b1;
            mwait_ff <= 1'b0;
         end else if (!rsp_stall) begin
            ov_ff <= 1'b0;
         end
      end
      if (do_exec) begin
         od_ff <= od_media ? mrd_ff : od_in;
         oi_ff <= irq_in && !control_in[1];
      end
   end
endmodule

### hw/rtl/ata_pio_task_file_device_unit.sv
`timescale 1ns / 1ps
// Channel | Ports                                   | Dir
// req     | req_valid req_stall req_cmd ...         | in
// rsp     | rsp_valid rsp_stall rsp_read_data rsp_irq | out
// csr     | csr_write csr_index csr_data            | in
// One item per cycle for register accesses unless rsp stalls; media data
// reads wait for the registered read of the media RAM.
// Synchronous active-high reset restores task file defaults; media is
// not cleared. A two-entry queue lets req proceed while rsp stalls.
module ata_pio_task_file_device_unit import ata_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [3:0]  req_reg_offset,
   input  logic [15:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_read_data,
   output logic        rsp_irq,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [27:0] csr_data
);
   logic    q_valid, q_pop;
   acc_type q_data;

   ata_front u_front (.clock, .reset, .req_valid, .req_stall, .req_cmd,
      .req_reg_offset, .req_write_data, .q_valid, .q_data, .q_pop);

   ata_back u_back (.clock, .reset, .csr_write, .csr_index, .csr_data,
      .q_valid, .q_data, .q_pop, .rsp_valid, .rsp_stall, .rsp_read_data, .rsp_irq);
endmodule
